>>> rtl/indexed_min_heap_queue_top_defines.svh
// Assertion macros for the indexed min-heap queue.
// Included by the top level; takes no other file.
`ifndef INDEXED_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTH
`define IMHQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("imhq assertion failed");
`define IMHQ_ASSERT_NEVER(label, clk, rst, cond) \
   `IMHQ_ASSERT(label, clk, rst, !(cond))
`else
`define IMHQ_ASSERT(label, clk, rst, prop)
`define IMHQ_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

>>> rtl/imhq_pkg.sv
// Types and constants shared by the indexed min-heap queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package imhq_pkg;

   localparam int ID_IN_W  = 10;
   localparam int KEY_IN_W = 32;
   localparam int SIZE_W   = 11;

   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_POP    = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_UPDATE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_FULL    = 3'd2,
      ST_ABSENT  = 3'd3,
      ST_PRESENT = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CLEAR,
      CMD_LOOKUP,
      CMD_SET_STATUS,
      CMD_PUSH_SETUP,
      CMD_UPDATE_SETUP,
      CMD_TAKE_GONE,
      CMD_TAKE_LAST,
      CMD_TAKE_MOVE,
      CMD_RISE_RD,
      CMD_RISE_MOVE,
      CMD_SINK_RDL,
      CMD_SINK_RDR,
      CMD_SINK_MOVE,
      CMD_PLACE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      status_type code;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     id_valid;
      logic     present;
      logic     full;
      logic     empty;
      logic     key_zero;
      logic     rise_ok;
      logic     parent_greater;
      logic     has_left;
      logic     child_less;
      logic     take_resettle;
      logic     out_free;
      logic     clear_done;
   } dp_status_type;

   typedef enum logic [13:0] {
      S_CLEAR     = 14'b00000000000001,
      S_IDLE      = 14'b00000000000010,
      S_LOOKUP    = 14'b00000000000100,
      S_DECIDE    = 14'b00000000001000,
      S_TAKE_GONE = 14'b00000000010000,
      S_TAKE_LAST = 14'b00000000100000,
      S_TAKE_MOVE = 14'b00000001000000,
      S_RISE_CHK  = 14'b00000010000000,
      S_RISE_CMP  = 14'b00000100000000,
      S_SINK_CHK  = 14'b00001000000000,
      S_SINK_RDR  = 14'b00010000000000,
      S_SINK_CMP  = 14'b00100000000000,
      S_PLACE     = 14'b01000000000000,
      S_FINISH    = 14'b10000000000000
   } state_type;

endpackage
`default_nettype wire

>>> rtl/imhq_if.sv
// Request and response channel interfaces of the indexed min-heap queue.
// Depends on nothing but the field widths fixed here.
`timescale 1ns / 1ps
`default_nettype none
interface imhq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [9:0]  entry_id;
   logic [31:0] priority_key;
   modport source (output valid, mode, entry_id, priority_key, input ready);
   modport sink (input valid, mode, entry_id, priority_key, output ready);
endinterface

interface imhq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [9:0]  popped_id;
   logic [31:0] popped_key;
   logic [10:0] heap_size;
   modport source (output valid, status, popped_id, popped_key, heap_size, input ready);
   modport sink (input valid, status, popped_id, popped_key, heap_size, output ready);
endinterface
`default_nettype wire

>>> rtl/imhq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module imhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> rtl/imhq_ctrl.sv
// Controller state machine of the indexed min-heap queue.
// Depends on imhq_pkg for states, commands and datapath status.
`timescale 1ns / 1ps
`default_nettype none
module imhq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire imhq_pkg::dp_status_type status,
   output imhq_pkg::cmd_type            cmd
);

   imhq_pkg::state_type state_ff, state_in;
   imhq_pkg::state_type after_rise;

   always_comb begin
      after_rise = (status.mode == imhq_pkg::MODE_PUSH) ? imhq_pkg::S_PLACE
                                                         : imhq_pkg::S_SINK_CHK;
      state_in   = state_ff;
      cmd.op     = imhq_pkg::CMD_NONE;
      cmd.code   = imhq_pkg::ST_OK;
      cmd.finish = 1'b0;
      unique case (state_ff)
         imhq_pkg::S_CLEAR: begin
            cmd.op = imhq_pkg::CMD_CLEAR;
            if (status.clear_done) begin
               state_in = imhq_pkg::S_IDLE;
            end
         end
         imhq_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.op   = imhq_pkg::CMD_LOAD;
               state_in = imhq_pkg::S_LOOKUP;
            end
         end
         imhq_pkg::S_LOOKUP: begin
            cmd.op   = imhq_pkg::CMD_LOOKUP;
            state_in = imhq_pkg::S_DECIDE;
         end
         imhq_pkg::S_DECIDE: begin
            state_in = imhq_pkg::S_FINISH;
            cmd.op   = imhq_pkg::CMD_SET_STATUS;
            unique case (status.mode)
               imhq_pkg::MODE_PUSH: begin
                  if (!status.id_valid) begin
                     cmd.code = imhq_pkg::ST_ABSENT;
                  end else if (status.present) begin
                     cmd.code = imhq_pkg::ST_PRESENT;
                  end else if (status.full) begin
                     cmd.code = imhq_pkg::ST_FULL;
                  end else begin
                     cmd.op   = imhq_pkg::CMD_PUSH_SETUP;
                     state_in = imhq_pkg::S_RISE_CHK;
                  end
               end
               imhq_pkg::MODE_POP: begin
                  if (status.empty) begin
                     cmd.code = imhq_pkg::ST_EMPTY;
                  end else begin
                     cmd.op   = imhq_pkg::CMD_NONE;
                     state_in = imhq_pkg::S_TAKE_GONE;
                  end
               end
               imhq_pkg::MODE_REMOVE: begin
                  if (!status.present) begin
                     cmd.code = imhq_pkg::ST_ABSENT;
                  end else begin
                     cmd.op   = imhq_pkg::CMD_NONE;
                     state_in = imhq_pkg::S_TAKE_GONE;
                  end
               end
               default: begin
                  if (!status.present) begin
                     cmd.code = imhq_pkg::ST_ABSENT;
                  end else if (status.key_zero) begin
                     cmd.op   = imhq_pkg::CMD_NONE;
                     state_in = imhq_pkg::S_TAKE_GONE;
                  end else begin
                     cmd.op   = imhq_pkg::CMD_UPDATE_SETUP;
                     state_in = imhq_pkg::S_RISE_CHK;
                  end
               end
            endcase
         end
         imhq_pkg::S_TAKE_GONE: begin
            cmd.op   = imhq_pkg::CMD_TAKE_GONE;
            state_in = imhq_pkg::S_TAKE_LAST;
         end
         imhq_pkg::S_TAKE_LAST: begin
            cmd.op   = imhq_pkg::CMD_TAKE_LAST;
            state_in = imhq_pkg::S_TAKE_MOVE;
         end
         imhq_pkg::S_TAKE_MOVE: begin
            cmd.op   = imhq_pkg::CMD_TAKE_MOVE;
            state_in = status.take_resettle ? imhq_pkg::S_RISE_CHK : imhq_pkg::S_FINISH;
         end
         imhq_pkg::S_RISE_CHK: begin
            if (status.rise_ok) begin
               cmd.op   = imhq_pkg::CMD_RISE_RD;
               state_in = imhq_pkg::S_RISE_CMP;
            end else begin
               state_in = after_rise;
            end
         end
         imhq_pkg::S_RISE_CMP: begin
            if (status.parent_greater) begin
               cmd.op   = imhq_pkg::CMD_RISE_MOVE;
               state_in = imhq_pkg::S_RISE_CHK;
            end else begin
               state_in = after_rise;
            end
         end
         imhq_pkg::S_SINK_CHK: begin
            if (status.has_left) begin
               cmd.op   = imhq_pkg::CMD_SINK_RDL;
               state_in = imhq_pkg::S_SINK_RDR;
            end else begin
               state_in = imhq_pkg::S_PLACE;
            end
         end
         imhq_pkg::S_SINK_RDR: begin
            cmd.op   = imhq_pkg::CMD_SINK_RDR;
            state_in = imhq_pkg::S_SINK_CMP;
         end
         imhq_pkg::S_SINK_CMP: begin
            if (status.child_less) begin
               cmd.op   = imhq_pkg::CMD_SINK_MOVE;
               state_in = imhq_pkg::S_SINK_CHK;
            end else begin
               state_in = imhq_pkg::S_PLACE;
            end
         end
         imhq_pkg::S_PLACE: begin
            cmd.op   = imhq_pkg::CMD_PLACE;
            state_in = imhq_pkg::S_FINISH;
         end
         imhq_pkg::S_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = imhq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = imhq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imhq_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == imhq_pkg::S_IDLE);

endmodule
`default_nettype wire

>>> rtl/imhq_dpath.sv
// Datapath of the indexed min-heap queue: heap and position memories,
// the moving entry, the entry count and the response register.
// Depends on imhq_pkg and imhq_ram.
`timescale 1ns / 1ps
`default_nettype none
module imhq_dpath #(
   parameter int ENTRIES  = 1024,
   parameter int KEY_BITS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire imhq_pkg::cmd_type                     cmd,
   output imhq_pkg::dp_status_type                    status,
   input  wire logic [1:0]                            req_mode,
   input  wire logic [imhq_pkg::ID_IN_W-1:0]          req_entry_id,
   input  wire logic [imhq_pkg::KEY_IN_W-1:0]         req_priority_key,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [2:0]                                 rsp_status,
   output logic [imhq_pkg::ID_IN_W-1:0]               rsp_popped_id,
   output logic [imhq_pkg::KEY_IN_W-1:0]              rsp_popped_key,
   output logic [imhq_pkg::SIZE_W-1:0]                rsp_heap_size
);

   localparam int ID_W   = $clog2(ENTRIES);
   localparam int SLOT_W = $clog2(ENTRIES + 1);
   localparam int ENT_W  = ID_W + KEY_BITS;

   imhq_pkg::mode_type   mode_ff, mode_in;
   imhq_pkg::status_type res_status_ff, res_status_in;
   logic [imhq_pkg::ID_IN_W-1:0] id_ff, id_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [SLOT_W-1:0]    count_ff, count_in;
   logic [SLOT_W-1:0]    cur_slot_ff, cur_slot_in;
   logic [ID_W-1:0]      cur_id_ff, cur_id_in;
   logic [KEY_BITS-1:0]  cur_key_ff, cur_key_in;
   logic [SLOT_W-1:0]    target_ff, target_in;
   logic [ENT_W-1:0]     left_ff, left_in;
   logic [ID_W-1:0]      clr_ff, clr_in;
   logic [ID_W-1:0]      pop_id_ff, pop_id_in;
   logic [KEY_BITS-1:0]  pop_key_ff, pop_key_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   imhq_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [imhq_pkg::ID_IN_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [imhq_pkg::KEY_IN_W-1:0] rsp_key_ff, rsp_key_in;
   logic [imhq_pkg::SIZE_W-1:0]   rsp_size_ff, rsp_size_in;

   logic              heap_we, heap_re;
   logic [ID_W-1:0]   heap_waddr, heap_raddr;
   logic [ENT_W-1:0]  heap_wdata, heap_rdata;
   logic              pos_we, pos_re;
   logic [ID_W-1:0]   pos_waddr, pos_raddr;
   logic [SLOT_W-1:0] pos_wdata, pos_rdata;

   logic [ID_W-1:0]     hq_id;
   logic [KEY_BITS-1:0] hq_key;
   logic [KEY_BITS-1:0] left_key;
   logic [SLOT_W-1:0]   parent_slot;
   logic [SLOT_W:0]     left_slot;
   logic [SLOT_W:0]     count_x;
   logic                child_is_left;
   logic [ENT_W-1:0]    child_data;
   logic [SLOT_W-1:0]   child_slot;
   logic [ID_W-1:0]     id_addr;
   logic                id_valid;
   logic [SLOT_W-1:0]   lookup_target;

   imhq_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_heap_ram (
      .clock (clock),
      .we    (heap_we),
      .waddr (heap_waddr),
      .wdata (heap_wdata),
      .re    (heap_re),
      .raddr (heap_raddr),
      .rdata (heap_rdata)
   );

   imhq_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_pos_ram (
      .clock (clock),
      .we    (pos_we),
      .waddr (pos_waddr),
      .wdata (pos_wdata),
      .re    (pos_re),
      .raddr (pos_raddr),
      .rdata (pos_rdata)
   );

   assign hq_id         = heap_rdata[ENT_W-1:KEY_BITS];
   assign hq_key        = heap_rdata[KEY_BITS-1:0];
   assign left_key      = left_ff[KEY_BITS-1:0];
   assign parent_slot   = cur_slot_ff >> 1;
   assign left_slot     = {cur_slot_ff, 1'b0};
   assign count_x       = {1'b0, count_ff};
   assign child_is_left = (left_slot == count_x) || (left_key < hq_key);
   assign child_data    = child_is_left ? left_ff : heap_rdata;
   assign child_slot    = child_is_left ? SLOT_W'(left_slot) : SLOT_W'(left_slot + 1'b1);
   assign id_addr       = ID_W'(id_ff);
   assign id_valid      = (32'(id_ff) < 32'(ENTRIES));
   assign lookup_target = (mode_ff == imhq_pkg::MODE_POP) ? SLOT_W'(1) : pos_rdata;

   always_comb begin
      mode_in       = mode_ff;
      res_status_in = res_status_ff;
      id_in         = id_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      cur_slot_in   = cur_slot_ff;
      cur_id_in     = cur_id_ff;
      cur_key_in    = cur_key_ff;
      target_in     = target_ff;
      left_in       = left_ff;
      clr_in        = clr_ff;
      pop_id_in     = pop_id_ff;
      pop_key_in    = pop_key_ff;
      heap_we       = 1'b0;
      heap_waddr    = ID_W'(cur_slot_ff - 1'b1);
      heap_wdata    = {cur_id_ff, cur_key_ff};
      heap_re       = 1'b0;
      heap_raddr    = ID_W'(parent_slot - 1'b1);
      pos_we        = 1'b0;
      pos_waddr     = cur_id_ff;
      pos_wdata     = cur_slot_ff;
      pos_re        = 1'b0;
      pos_raddr     = id_addr;
      case (cmd.op)
         imhq_pkg::CMD_LOAD: begin
            mode_in       = imhq_pkg::mode_type'(req_mode);
            id_in         = req_entry_id;
            key_in        = KEY_BITS'(req_priority_key);
            res_status_in = imhq_pkg::ST_OK;
            pop_id_in     = '0;
            pop_key_in    = '0;
         end
         imhq_pkg::CMD_CLEAR: begin
            pos_we    = 1'b1;
            pos_waddr = clr_ff;
            pos_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end
         imhq_pkg::CMD_LOOKUP: begin
            pos_re = 1'b1;
         end
         imhq_pkg::CMD_SET_STATUS: begin
            res_status_in = cmd.code;
         end
         imhq_pkg::CMD_PUSH_SETUP: begin
            count_in    = count_ff + 1'b1;
            cur_slot_in = count_ff + 1'b1;
            cur_id_in   = id_addr;
            cur_key_in  = key_ff;
         end
         imhq_pkg::CMD_UPDATE_SETUP: begin
            cur_slot_in = pos_rdata;
            cur_id_in   = id_addr;
            cur_key_in  = key_ff;
         end
         imhq_pkg::CMD_TAKE_GONE: begin
            target_in  = lookup_target;
            heap_re    = 1'b1;
            heap_raddr = ID_W'(lookup_target - 1'b1);
         end
         imhq_pkg::CMD_TAKE_LAST: begin
            pos_we     = 1'b1;
            pos_waddr  = hq_id;
            pos_wdata  = '0;
            heap_re    = 1'b1;
            heap_raddr = ID_W'(count_ff - 1'b1);
            count_in   = count_ff - 1'b1;
            if (mode_ff == imhq_pkg::MODE_POP) begin
               pop_id_in  = hq_id;
               pop_key_in = hq_key;
            end
         end
         imhq_pkg::CMD_TAKE_MOVE: begin
            cur_id_in   = hq_id;
            cur_key_in  = hq_key;
            cur_slot_in = target_ff;
         end
         imhq_pkg::CMD_RISE_RD: begin
            heap_re = 1'b1;
         end
         imhq_pkg::CMD_RISE_MOVE: begin
            heap_we     = 1'b1;
            heap_wdata  = heap_rdata;
            pos_we      = 1'b1;
            pos_waddr   = hq_id;
            cur_slot_in = parent_slot;
         end
         imhq_pkg::CMD_SINK_RDL: begin
            heap_re    = 1'b1;
            heap_raddr = ID_W'(left_slot - 1'b1);
         end
         imhq_pkg::CMD_SINK_RDR: begin
            left_in    = heap_rdata;
            heap_re    = (left_slot < count_x);
            heap_raddr = ID_W'(left_slot);
         end
         imhq_pkg::CMD_SINK_MOVE: begin
            heap_we     = 1'b1;
            heap_wdata  = child_data;
            pos_we      = 1'b1;
            pos_waddr   = child_data[ENT_W-1:KEY_BITS];
            cur_slot_in = child_slot;
         end
         imhq_pkg::CMD_PLACE: begin
            heap_we = 1'b1;
            pos_we  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_size_in   = rsp_size_ff;
      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_id_in     = imhq_pkg::ID_IN_W'(pop_id_ff);
         rsp_key_in    = imhq_pkg::KEY_IN_W'(pop_key_ff);
         rsp_size_in   = imhq_pkg::SIZE_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      res_status_ff <= res_status_in;
      id_ff         <= id_in;
      key_ff        <= key_in;
      cur_slot_ff   <= cur_slot_in;
      cur_id_ff     <= cur_id_in;
      cur_key_ff    <= cur_key_in;
      target_ff     <= target_in;
      left_ff       <= left_in;
      pop_id_ff     <= pop_id_in;
      pop_key_ff    <= pop_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_size_ff   <= rsp_size_in;
   end

   always_comb begin
      status.mode           = mode_ff;
      status.id_valid       = id_valid;
      status.present        = id_valid && (pos_rdata != '0);
      status.full           = (count_ff == SLOT_W'(ENTRIES));
      status.empty          = (count_ff == '0);
      status.key_zero       = (key_ff == '0);
      status.rise_ok        = (cur_slot_ff > SLOT_W'(1));
      status.parent_greater = (hq_key > cur_key_ff);
      status.has_left       = (left_slot <= count_x);
      status.child_less     = (child_data[KEY_BITS-1:0] < cur_key_ff);
      status.take_resettle  = (target_ff <= count_ff);
      status.out_free       = !rsp_valid_ff || rsp_ready;
      status.clear_done     = (clr_ff == ID_W'(ENTRIES - 1));
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_popped_id  = rsp_id_ff;
   assign rsp_popped_key = rsp_key_ff;
   assign rsp_heap_size  = rsp_size_ff;

endmodule
`default_nettype wire

>>> rtl/indexed_min_heap_queue_top.sv
// Top level of the indexed min-heap queue: controller, datapath and checks.
// Depends on imhq_pkg, imhq_if, imhq_ctrl, imhq_dpath and the defines header.
//
// The queue holds up to ENTRIES ids in a binary min-heap ordered by an
// unsigned key, with a position memory that maps each id to its heap slot.
// One request is worked at a time; a new request is taken while the previous
// response still waits in the output register, and the next response waits
// in the controller until that register is free. A rejected request is
// loaded, looked up and decided. An accepted one is loaded, looked up and
// decided; when an entry is taken out, the last entry is read and moved into
// the gap. An entry then rises a level at a time by reading and comparing its
// parent and, but for a push, sinks a level at a time by reading its
// children and comparing, before it is placed and answered. The single read
// port of the heap memory sets the per-level cost. After reset a clearing
// pass zeroes the position memory, and no request is taken during it.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_min_heap_queue_top_defines.svh"
module indexed_min_heap_queue_top #(
   parameter int ENTRIES  = 1024,
   parameter int KEY_BITS = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   imhq_req_if.sink   req_bus,
   imhq_rsp_if.source rsp_bus
);

   imhq_pkg::cmd_type       ctrl_cmd;
   imhq_pkg::dp_status_type dp_status;

   imhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   imhq_dpath #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctrl_cmd),
      .status           (dp_status),
      .req_mode         (req_bus.mode),
      .req_entry_id     (req_bus.entry_id),
      .req_priority_key (req_bus.priority_key),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_status       (rsp_bus.status),
      .rsp_popped_id    (rsp_bus.popped_id),
      .rsp_popped_key   (rsp_bus.popped_key),
      .rsp_heap_size    (rsp_bus.heap_size)
   );

   `IMHQ_ASSERT(a_one_at_a_time, clock, reset, (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
   `IMHQ_ASSERT(a_finish_when_free, clock, reset, ctrl_cmd.finish |-> dp_status.out_free)
   `IMHQ_ASSERT(a_pop_fields_zero, clock, reset, (rsp_bus.valid && rsp_bus.status != imhq_pkg::ST_OK) |-> (rsp_bus.popped_id == '0 && rsp_bus.popped_key == '0))
   `IMHQ_ASSERT_NEVER(a_empty_size, clock, reset, rsp_bus.valid && rsp_bus.status == imhq_pkg::ST_EMPTY && rsp_bus.heap_size != '0)

endmodule
`default_nettype wire
